// ===== design/sensor_measurement_frame_decoder_assert.svh =====
// Assertion macros shared by the frame decoder RTL.
// Both expect clk_i and rst_ni in the enclosing module.
`ifndef SENSOR_MEASUREMENT_FRAME_DECODER_ASSERT_SVH
`define SENSOR_MEASUREMENT_FRAME_DECODER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define SMFD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("frame decoder: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define SMFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame decoder: sequence violated");

`endif

// ===== design/smfd_pkg.sv =====
package smfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [3:0] LastPos = 4'd8;

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumidScale = 14'd10000;
  localparam logic signed [15:0] TempOffset = 16'sd4500;

  typedef enum logic [1:0] {
    SLOT_HIGH = 2'd0,
    SLOT_LOW  = 2'd1,
    SLOT_CRC  = 2'd2
  } slot_e;

  // Converted temperature and humidity for one frame
  typedef struct packed {
    logic signed [14:0] temp_centideg;
    logic [13:0]        humidity_centipct;
  } conv_t;

  // One byte through the CRC-8, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/sensor_measurement_frame_decoder.sv =====
// The result of a frame is registered on the transfer of its ninth byte.
// Throughput: one byte per cycle; the result register parts the two sides,
// and input stalls only while a finished result is held by output stall.
// Reset (rst_ni low, asynchronous): byte position 0, CRC 0xFF, words and the
// error flag cleared, no result pending.
`include "sensor_measurement_frame_decoder_assert.svh"

module sensor_measurement_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        co2_ppm_o,
  output logic signed [14:0] temp_centideg_o,
  output logic [13:0]        humidity_centipct_o,
  output logic               crc_ok_o
);

  logic [3:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  high_q, high_d;
  logic [15:0] co2_q, co2_d;
  logic [15:0] temp_q, temp_d;
  logic [15:0] humid_q, humid_d;
  logic        crc_err_q, crc_err_d;
  logic        out_valid_q, out_valid_d;

  logic [15:0]        out_co2_q;
  logic signed [14:0] out_temp_q;
  logic [13:0]        out_humid_q;
  logic               out_crc_ok_q;

  logic                in_xfer;
  logic                restart;
  logic [3:0]          pos;
  logic [7:0]          crc_base;
  logic                err_base;
  logic                err_now;
  logic                frame_done;
  smfd_pkg::slot_e     slot;
  smfd_pkg::conv_t     conv;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Start flag or a stray position drops the partial frame
  assign restart  = frame_start_i || (byte_pos_q > smfd_pkg::LastPos);
  assign pos      = restart ? 4'd0 : byte_pos_q;
  assign crc_base = restart ? smfd_pkg::CrcInit : crc_q;
  assign err_base = restart ? 1'b0 : crc_err_q;

  always_comb begin
    case (pos) inside
      4'd0, 4'd3, 4'd6: slot = smfd_pkg::SLOT_HIGH;
      4'd1, 4'd4, 4'd7: slot = smfd_pkg::SLOT_LOW;
      default:          slot = smfd_pkg::SLOT_CRC;
    endcase
  end

  assign err_now    = err_base || ((slot == smfd_pkg::SLOT_CRC) && (crc_base != rx_byte_i));
  assign frame_done = in_xfer && (pos == smfd_pkg::LastPos);

  always_comb begin
    byte_pos_d = byte_pos_q;
    crc_d      = crc_q;
    high_d     = high_q;
    co2_d      = co2_q;
    temp_d     = temp_q;
    humid_d    = humid_q;
    crc_err_d  = crc_err_q;
    if (in_xfer) begin
      crc_err_d = err_now;
      case (slot)
        smfd_pkg::SLOT_HIGH: begin
          crc_d  = smfd_pkg::crc8_step(smfd_pkg::CrcInit, rx_byte_i);
          high_d = rx_byte_i;
        end
        smfd_pkg::SLOT_LOW: begin
          crc_d = smfd_pkg::crc8_step(crc_base, rx_byte_i);
          case (pos)
            4'd1:    co2_d   = {high_q, rx_byte_i};
            4'd4:    temp_d  = {high_q, rx_byte_i};
            default: humid_d = {high_q, rx_byte_i};
          endcase
        end
        default: begin
          crc_d = smfd_pkg::CrcInit;
        end
      endcase
      if (pos == smfd_pkg::LastPos) begin
        byte_pos_d = 4'd0;
        crc_err_d  = 1'b0;
      end else begin
        byte_pos_d = pos + 4'd1;
      end
    end
  end

  // Words are complete a byte before the frame ends, so convert from registers
  smfd_conv u_conv (
    .temp_word_i  (temp_q),
    .humid_word_i (humid_q),
    .conv_o       (conv)
  );

  assign out_valid_d = frame_done || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= 4'd0;
      crc_q       <= smfd_pkg::CrcInit;
      high_q      <= 8'd0;
      co2_q       <= 16'd0;
      temp_q      <= 16'd0;
      humid_q     <= 16'd0;
      crc_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      crc_q       <= crc_d;
      high_q      <= high_d;
      co2_q       <= co2_d;
      temp_q      <= temp_d;
      humid_q     <= humid_d;
      crc_err_q   <= crc_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      out_co2_q    <= co2_q;
      out_temp_q   <= conv.temp_centideg;
      out_humid_q  <= conv.humidity_centipct;
      out_crc_ok_q <= !err_now;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign co2_ppm_o           = out_co2_q;
  assign temp_centideg_o     = out_temp_q;
  assign humidity_centipct_o = out_humid_q;
  assign crc_ok_o            = out_crc_ok_q;

  `SMFD_ASSERT_ALWAYS(a_pos_range, byte_pos_q <= smfd_pkg::LastPos)
  `SMFD_ASSERT_ALWAYS(a_crc_idle_at_word, (byte_pos_q != 4'd0 && byte_pos_q != 4'd3 && byte_pos_q != 4'd6) || crc_q == smfd_pkg::CrcInit)
  `SMFD_ASSERT_NEXT(a_done_emits, frame_done, out_valid_o && byte_pos_q == 4'd0)
  `SMFD_ASSERT_NEXT(a_start_realigns, in_xfer && frame_start_i, byte_pos_q == 4'd1)

endmodule

// ===== design/smfd_conv.sv =====
module smfd_conv (
  input  logic [15:0]    temp_word_i,
  input  logic [15:0]    humid_word_i,
  output smfd_pkg::conv_t conv_o
);

  logic [30:0]        temp_prod;
  logic [29:0]        humid_prod;
  logic signed [15:0] temp_wide;

  assign temp_prod  = 31'(temp_word_i) * 31'(smfd_pkg::TempScale);
  assign humid_prod = 30'(humid_word_i) * 30'(smfd_pkg::HumidScale);

  // Scaled value reaches 17499, so subtract in 16 bits and trim afterwards
  assign temp_wide = $signed({1'b0, temp_prod[30:16]}) - smfd_pkg::TempOffset;

  assign conv_o.temp_centideg     = temp_wide[14:0];
  assign conv_o.humidity_centipct = humid_prod[29:16];

endmodule

// ===== bench/sensor_measurement_frame_decoder_test.sv =====
`timescale 1ns / 100ps

module sensor_measurement_frame_decoder_test;

  localparam int unsigned ClkHalf      = 2;
  localparam int unsigned TimeoutNs    = 2_000_000;
  localparam int unsigned RandomItems  = 1550;
  localparam int unsigned TotalItems   = 1950;
  localparam int unsigned LongHold     = 80;
  localparam int unsigned MaxPrinted   = 40;
  localparam int unsigned DrainCycles  = 8;

  localparam logic [1:0] WordCo2  = 2'd0;
  localparam logic [1:0] WordTemp = 2'd1;

  typedef struct {
    logic [15:0]        co2;
    logic signed [14:0] temp;
    logic [13:0]        humid;
    logic               ok;
  } reading_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               frame_start_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [15:0]        co2_ppm_o;
  logic signed [14:0] temp_centideg_o;
  logic [13:0]        humidity_centipct_o;
  logic               crc_ok_o;

  sensor_measurement_frame_decoder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .rx_byte_i           (rx_byte_i),
    .frame_start_i       (frame_start_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .co2_ppm_o           (co2_ppm_o),
    .temp_centideg_o     (temp_centideg_o),
    .humidity_centipct_o (humidity_centipct_o),
    .crc_ok_o            (crc_ok_o)
  );

  // Decoder state as the bench sees it
  logic [3:0]  frame_pos = '0;
  logic [7:0]  crc_acc   = smfd_pkg::CrcInit;
  logic [7:0]  hi_byte   = '0;
  logic [15:0] co2_w     = '0;
  logic [15:0] temp_w    = '0;
  logic [15:0] humid_w   = '0;
  logic        crc_bad   = 1'b0;

  reading_t    pending_readings[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  bit          tx_gaps_on     = 1'b1;
  bit          rx_stalls_on   = 1'b1;
  bit          hold_off_req   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  initial begin
    #TimeoutNs;
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] crc_after_byte(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       msb;
    r = acc ^ data;
    repeat (8) begin
      msb = r[7];
      r   = r << 1;
      if (msb) r = r ^ smfd_pkg::CrcPoly;
    end
    return r;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc_after_byte(crc_after_byte(smfd_pkg::CrcInit, w[15:8]), w[7:0]);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Advance the frame by one transferred byte; queue a reading after the ninth
  task automatic decode_readout_byte(input logic [7:0] b, input logic start);
    logic [3:0]      pos;
    smfd_pkg::slot_e slot;
    logic [1:0]      word_idx;
    logic [31:0]     t_prod;
    logic [31:0]     h_prod;
    reading_t        r;
    if (start || frame_pos > smfd_pkg::LastPos) begin
      frame_pos = '0;
      crc_acc   = smfd_pkg::CrcInit;
      crc_bad   = 1'b0;
    end
    pos      = frame_pos;
    slot     = smfd_pkg::slot_e'(2'(pos % 3));
    word_idx = 2'(pos / 3);
    case (slot)
      smfd_pkg::SLOT_HIGH: begin
        crc_acc = crc_after_byte(smfd_pkg::CrcInit, b);
        hi_byte = b;
      end
      smfd_pkg::SLOT_LOW: begin
        crc_acc = crc_after_byte(crc_acc, b);
        if (word_idx == WordCo2) co2_w = {hi_byte, b};
        else if (word_idx == WordTemp) temp_w = {hi_byte, b};
        else humid_w = {hi_byte, b};
      end
      default: begin
        if (crc_acc != b) crc_bad = 1'b1;
        crc_acc = smfd_pkg::CrcInit;
      end
    endcase
    if (pos == smfd_pkg::LastPos) begin
      t_prod  = (32'(temp_w) * 32'(smfd_pkg::TempScale)) >> 16;
      h_prod  = (32'(humid_w) * 32'(smfd_pkg::HumidScale)) >> 16;
      r.co2   = co2_w;
      r.temp  = 15'(t_prod - 32'(smfd_pkg::TempOffset));
      r.humid = h_prod[13:0];
      r.ok    = !crc_bad;
      pending_readings.push_back(r);
      frame_pos = '0;
      crc_acc   = smfd_pkg::CrcInit;
      crc_bad   = 1'b0;
    end else begin
      frame_pos = pos + 4'd1;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MaxPrinted) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) decode_readout_byte(rx_byte_i, frame_start_i);
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("unexpected reading, co2", co2_ppm_o, -1);
      end else begin
        want = pending_readings.pop_front();
        if (co2_ppm_o !== want.co2) flag_mismatch("co2_ppm", co2_ppm_o, want.co2);
        if (temp_centideg_o !== want.temp) begin
          flag_mismatch("temp_centideg", temp_centideg_o, want.temp);
        end
        if (humidity_centipct_o !== want.humid) begin
          flag_mismatch("humidity_centipct", humidity_centipct_o, want.humid);
        end
        if (crc_ok_o !== want.ok) flag_mismatch("crc_ok", crc_ok_o, want.ok);
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i    <= 1'b0;
      rx_byte_i     <= 8'($urandom);
      frame_start_i <= 1'($urandom);
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // bad marks words whose CRC byte is corrupted, bit 0 for CO2
  task automatic send_frame(input logic [15:0] co2, input logic [15:0] temp,
                            input logic [15:0] humid, input logic start,
                            input logic [2:0] bad);
    logic [15:0] w[3];
    logic [7:0]  c;
    w = '{co2, temp, humid};
    for (int k = 0; k < 3; k++) begin
      c = word_crc(w[k]);
      if (bad[k]) c = c ^ 8'($urandom_range(1, 255));
      send_byte(w[k][15:8], start && k == 0);
      send_byte(w[k][7:0], 1'b0);
      send_byte(c, 1'b0);
    end
  endtask

  task automatic test_extremes();
    send_frame(16'h0000, 16'h0000, 16'h0000, 1'b1, 3'b000);
    // no start flag: the position wraps into the next frame
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 3'b001);
  endtask

  task automatic test_restart();
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame(16'hBEEF, 16'h6666, 16'h9999, 1'b1, 3'b110);
  endtask

  task automatic test_random_traffic();
    bit need_start;
    int unsigned n;
    need_start = 1'b1;
    while (bytes_sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // truncated frame, dropped by the next start flag
          n = $urandom_range(1, 8);
          send_byte(8'($urandom), 1'b1);
          repeat (n - 1) send_byte(8'($urandom), 1'b0);
          need_start = 1'b1;
        end
        2: begin
          n = $urandom_range(1, 12);
          repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
          need_start = 1'b1;
        end
        default: begin
          send_frame(pick_word(), pick_word(), pick_word(),
                     need_start || $urandom_range(0, 3) != 0,
                     {$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                      $urandom_range(0, 4) == 0});
          need_start = 1'b0;
        end
      endcase
    end
    if (need_start) send_frame(pick_word(), pick_word(), pick_word(), 1'b1, 3'b000);
  endtask

  // Hold the result side off while frames keep coming, so input stalls
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (3) send_frame(pick_word(), pick_word(), pick_word(), 1'b1, 3'b000);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_full_rate();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    while (bytes_sent < TotalItems) begin
      send_frame(pick_word(), pick_word(), pick_word(), $urandom_range(0, 1),
                 {$urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                  $urandom_range(0, 5) == 0});
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    rx_byte_i     <= '0;
    frame_start_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_restart();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    in_valid_i <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
